// File: design/assert_macros.svh
// Shared assertion macros. Clock and reset are the block's own port names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/dllp_pkg.sv
package dllp_pkg;

   localparam int POOL_SLOTS_DEF = 64;
   localparam int ITEM_WIDTH_DEF = 32;

   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_REMOVE     = 3'd4;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_EMPTY     = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STATUS_ZERO      = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_POP_A,
      ST_POP_B,
      ST_WALK_A,
      ST_WALK_B
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic decide;
      logic push_a;
      logic push_b;
      logic pop_a;
      logic pop_b;
      logic walk_a;
      logic walk_b;
      logic finish;
   } dllp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic err;
      logic is_push;
      logic is_pop;
      logic is_remove;
      logic hit;
      logic walk_end;
      logic out_free;
   } dllp_stat_type;

endpackage

// File: design/doubly_linked_list_pool_core.sv
// Doubly linked list held in a pool of POOL_SLOTS slots, with a chain of free slots.
// Request channel (req_valid/req_ready): kind and item_value. Kinds are push front,
// push back, pop front, pop back and remove the first slot holding item_value.
// Response channel (rsp_valid/rsp_ready): status, popped item, slot used, item count
// after the request and the revision counter. Every item gives exactly one response.
// One item is worked on at a time. A failed request needs no memory read; a push
// or pop waits on the registered reads of the link memories, and a remove walks
// the list from the head, one memory read per slot visited. The next item is
// accepted in the cycle after its predecessor's response is loaded, so no new item
// is taken before the last one is through. A response may wait in its register
// while the next item is at work.
// When the receiver stalls, a finished item holds in the controller until the
// response register is free, and no new item is accepted meanwhile.
// Reset is synchronous: the list comes up empty, the revision counter at zero, and
// the free slots are handed out in ascending order until freed slots come back,
// which are reused last in, first out. No clearing pass is needed.
module doubly_linked_list_pool_core
   import dllp_pkg::*;
#(
   parameter int POOL_SLOTS = POOL_SLOTS_DEF,
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_kind,
   input  logic [31:0]                        req_item_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [31:0]                        rsp_item_out,
   output logic [$clog2(POOL_SLOTS)-1:0]      rsp_slot,
   output logic [$clog2(POOL_SLOTS + 1)-1:0]  rsp_count,
   output logic [31:0]                        rsp_version
);

   // Commands and status between the sequencer and the datapath.
   dllp_cmd_type  cmd;
   dllp_stat_type stat;

   dllp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .stat(stat), .cmd(cmd)
   );

   dllp_datapath #(.POOL_SLOTS(POOL_SLOTS), .ITEM_WIDTH(ITEM_WIDTH)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_kind(req_kind), .req_item_value(req_item_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_item_out(rsp_item_out), .rsp_slot(rsp_slot), .rsp_count(rsp_count),
      .rsp_version(rsp_version)
   );

endmodule

// File: design/dllp_ram.sv
module dllp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/dllp_ctrl.sv
module dllp_ctrl
   import dllp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dllp_stat_type stat,
   output dllp_cmd_type  cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.err) begin
               state_in = ST_WALK_B;
            end else if (stat.is_push) begin
               state_in = ST_PUSH_A;
            end else if (stat.is_pop) begin
               state_in = ST_POP_A;
            end else begin
               state_in = ST_WALK_A;
            end
         end
         ST_PUSH_A: begin
            cmd.push_a = 1'b1;
            state_in   = ST_PUSH_B;
         end
         ST_PUSH_B: begin
            cmd.push_b = 1'b1;
            state_in   = ST_WALK_B;
         end
         ST_POP_A: begin
            cmd.pop_a = 1'b1;
            state_in  = ST_POP_B;
         end
         ST_POP_B: begin
            cmd.pop_b = 1'b1;
            state_in  = ST_WALK_B;
         end
         ST_WALK_A: begin
            cmd.walk_a = 1'b1;
            state_in   = ST_WALK_B;
         end
         ST_WALK_B: begin
            // Also serves as the hand-over state once an item's work is done.
            if (stat.is_remove) begin
               cmd.walk_b = 1'b1;
               state_in   = (stat.hit || stat.walk_end) ? ST_WALK_B : ST_WALK_A;
            end else begin
               cmd.finish = stat.out_free;
               state_in   = stat.out_free ? ST_IDLE : ST_WALK_B;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/dllp_datapath.sv
`include "assert_macros.svh"
module dllp_datapath
   import dllp_pkg::*;
#(
   parameter int POOL_SLOTS = POOL_SLOTS_DEF,
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
   localparam int SW = $clog2(POOL_SLOTS),
   localparam int LW = SW + 1,
   localparam int CW = $clog2(POOL_SLOTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  dllp_cmd_type  cmd,
   output dllp_stat_type stat,
   input  logic [2:0]    req_kind,
   input  logic [31:0]   req_item_value,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    rsp_status,
   output logic [31:0]   rsp_item_out,
   output logic [SW-1:0] rsp_slot,
   output logic [CW-1:0] rsp_count,
   output logic [31:0]   rsp_version
);

   localparam logic [LW-1:0] LINK_END = LW'(POOL_SLOTS);
   localparam logic [CW-1:0] FULL_COUNT = CW'(POOL_SLOTS);

   logic [2:0]            kind_ff;
   logic [ITEM_WIDTH-1:0] val_ff;
   logic [2:0]            status_ff;
   logic [ITEM_WIDTH-1:0] item_ff;
   logic [SW-1:0]         slot_ff;
   logic [LW-1:0]         head_ff, tail_ff, free_ff, fresh_ff, p_ff;
   logic [CW-1:0]         used_ff, steps_ff;
   logic [31:0]           ver_ff;
   logic                  rsp_valid_ff;
   logic [2:0]            rsp_status_ff;
   logic [31:0]           rsp_item_ff, rsp_version_ff;
   logic [SW-1:0]         rsp_slot_ff;
   logic [CW-1:0]         rsp_count_ff;

   logic                  item_we, next_we, prev_we, chain_we;
   logic [SW-1:0]         item_wa, next_wa, prev_wa, chain_wa, rd_addr;
   logic [LW-1:0]         next_wd, prev_wd, chain_wd;
   logic [ITEM_WIDTH-1:0] item_rd;
   logic [LW-1:0]         next_rd, prev_rd, chain_rd;

   logic       head_null, tail_null, is_front, val_zero, pool_full;
   logic [2:0] err_code;
   logic       walk_hit, walk_end;
   logic       nx_null, pr_null;

   assign head_null = head_ff >= LINK_END;
   assign tail_null = tail_ff >= LINK_END;
   assign is_front  = (kind_ff == KIND_PUSH_FRONT) || (kind_ff == KIND_POP_FRONT);
   assign val_zero  = val_ff == '0;
   assign pool_full = (used_ff >= FULL_COUNT) || (free_ff >= LINK_END);
   assign nx_null   = next_rd >= LINK_END;
   assign pr_null   = prev_rd >= LINK_END;
   assign walk_hit  = item_rd == val_ff;
   assign walk_end  = !walk_hit && (nx_null || (CW'(steps_ff + 1'b1) == FULL_COUNT));

   always_comb begin
      case (kind_ff)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            err_code = val_zero ? STATUS_ZERO : (pool_full ? STATUS_FULL : STATUS_OK);
         end
         KIND_POP_FRONT: err_code = head_null ? STATUS_EMPTY : STATUS_OK;
         KIND_POP_BACK:  err_code = tail_null ? STATUS_EMPTY : STATUS_OK;
         KIND_REMOVE: begin
            err_code = val_zero ? STATUS_ZERO : (head_null ? STATUS_NOT_FOUND : STATUS_OK);
         end
         default: err_code = STATUS_NOT_FOUND;
      endcase
   end

   always_comb begin
      stat.err       = err_code != STATUS_OK;
      stat.is_push   = (kind_ff == KIND_PUSH_FRONT) || (kind_ff == KIND_PUSH_BACK);
      stat.is_pop    = (kind_ff == KIND_POP_FRONT) || (kind_ff == KIND_POP_BACK);
      stat.is_remove = (kind_ff == KIND_REMOVE) && (status_ff == STATUS_OK) && slot_ff == '0
                       && p_ff != LINK_END;
      stat.hit       = walk_hit;
      stat.walk_end  = walk_end;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Memory port selection for each phase.
   always_comb begin
      item_we  = 1'b0;
      next_we  = 1'b0;
      prev_we  = 1'b0;
      chain_we = 1'b0;
      item_wa  = slot_ff;
      next_wa  = slot_ff;
      prev_wa  = slot_ff;
      chain_wa = slot_ff;
      next_wd  = LINK_END;
      prev_wd  = LINK_END;
      chain_wd = free_ff;
      rd_addr  = cmd.walk_a ? p_ff[SW-1:0] : slot_ff;
      if (cmd.push_a) begin
         item_we = 1'b1;
         next_we = 1'b1;
         prev_we = 1'b1;
         next_wd = is_front ? head_ff : LINK_END;
         prev_wd = is_front ? LINK_END : tail_ff;
      end else if (cmd.push_b) begin
         if (is_front) begin
            prev_we = !head_null;
            prev_wa = head_ff[SW-1:0];
            prev_wd = LW'(slot_ff);
         end else begin
            next_we = !tail_null;
            next_wa = tail_ff[SW-1:0];
            next_wd = LW'(slot_ff);
         end
      end else if (cmd.pop_b) begin
         chain_we = 1'b1;
         if (is_front) begin
            prev_we = !nx_null;
            prev_wa = next_rd[SW-1:0];
         end else begin
            next_we = !pr_null;
            next_wa = prev_rd[SW-1:0];
         end
      end else if (cmd.walk_b && stat.is_remove && walk_hit) begin
         chain_we = 1'b1;
         chain_wa = p_ff[SW-1:0];
         next_we  = !pr_null;
         next_wa  = prev_rd[SW-1:0];
         next_wd  = next_rd;
         prev_we  = !nx_null;
         prev_wa  = next_rd[SW-1:0];
         prev_wd  = prev_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= LINK_END;
         tail_ff      <= LINK_END;
         free_ff      <= '0;
         fresh_ff     <= '0;
         used_ff      <= '0;
         ver_ff       <= '0;
         p_ff         <= LINK_END;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end
         if (cmd.load) begin
            p_ff <= LINK_END;
         end else if (cmd.decide) begin
            p_ff <= (kind_ff == KIND_REMOVE && err_code == STATUS_OK) ? head_ff : LINK_END;
         end else if (cmd.push_b) begin
            // A never used slot is followed by the next one up the pool.
            if (free_ff == fresh_ff) begin
               free_ff  <= fresh_ff + 1'b1;
               fresh_ff <= fresh_ff + 1'b1;
            end else begin
               free_ff <= chain_rd;
            end
            used_ff <= used_ff + 1'b1;
            ver_ff  <= ver_ff + 1'b1;
            if (is_front) begin
               head_ff <= LW'(slot_ff);
               if (head_null) begin
                  tail_ff <= LW'(slot_ff);
               end
            end else begin
               tail_ff <= LW'(slot_ff);
               if (tail_null) begin
                  head_ff <= LW'(slot_ff);
               end
            end
         end else if (cmd.pop_b) begin
            free_ff <= LW'(slot_ff);
            used_ff <= used_ff - 1'b1;
            ver_ff  <= ver_ff + 1'b1;
            if (is_front) begin
               head_ff <= next_rd;
               if (nx_null) begin
                  tail_ff <= LINK_END;
               end
            end else begin
               tail_ff <= prev_rd;
               if (pr_null) begin
                  head_ff <= LINK_END;
               end
            end
         end else if (cmd.walk_b && stat.is_remove) begin
            if (walk_hit) begin
               free_ff <= p_ff;
               used_ff <= used_ff - 1'b1;
               ver_ff  <= ver_ff + 1'b1;
               if (pr_null) begin
                  head_ff <= next_rd;
               end
               if (nx_null) begin
                  tail_ff <= prev_rd;
               end
               p_ff <= LINK_END;
            end else if (walk_end) begin
               p_ff <= LINK_END;
            end else begin
               p_ff <= next_rd;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         val_ff    <= ITEM_WIDTH'(req_item_value);
         status_ff <= STATUS_OK;
         item_ff   <= '0;
         slot_ff   <= '0;
         steps_ff  <= '0;
      end else if (cmd.decide) begin
         status_ff <= err_code;
         steps_ff  <= '0;
         if (err_code == STATUS_OK && stat.is_push) begin
            slot_ff <= free_ff[SW-1:0];
         end else if (err_code == STATUS_OK && kind_ff == KIND_POP_FRONT) begin
            slot_ff <= head_ff[SW-1:0];
         end else if (err_code == STATUS_OK && kind_ff == KIND_POP_BACK) begin
            slot_ff <= tail_ff[SW-1:0];
         end
      end else if (cmd.pop_b) begin
         item_ff <= item_rd;
      end else if (cmd.walk_b && stat.is_remove) begin
         if (walk_hit) begin
            slot_ff <= p_ff[SW-1:0];
         end else if (walk_end) begin
            status_ff <= STATUS_NOT_FOUND;
         end else begin
            steps_ff <= steps_ff + 1'b1;
         end
      end
      if (cmd.finish) begin
         rsp_status_ff  <= status_ff;
         rsp_item_ff    <= 32'(item_ff);
         rsp_slot_ff    <= slot_ff;
         rsp_count_ff   <= used_ff;
         rsp_version_ff <= ver_ff;
      end
   end

   dllp_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(POOL_SLOTS)) u_item_ram (
      .clock(clock), .we(item_we), .waddr(item_wa), .wdata(val_ff),
      .raddr(rd_addr), .rdata(item_rd)
   );
   dllp_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_next_ram (
      .clock(clock), .we(next_we), .waddr(next_wa), .wdata(next_wd),
      .raddr(rd_addr), .rdata(next_rd)
   );
   dllp_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_prev_ram (
      .clock(clock), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
      .raddr(rd_addr), .rdata(prev_rd)
   );
   dllp_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_chain_ram (
      .clock(clock), .we(chain_we), .waddr(chain_wa), .wdata(chain_wd),
      .raddr(rd_addr), .rdata(chain_rd)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_item_out = rsp_item_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_version = rsp_version_ff;

   `ASSERT_ALWAYS(a_count_bound, used_ff <= FULL_COUNT, "item count beyond pool size")
   `ASSERT_ALWAYS(a_ends_agree, head_null == tail_null, "head and tail disagree on empty")
   `ASSERT_ALWAYS(a_empty_count, head_null == (used_ff == '0), "count disagrees with list")
   `ASSERT_NEXT(a_push_count, cmd.push_b, used_ff == CW'($past(used_ff) + 1'b1),
      "push did not raise the count")

endmodule

// File: verif/tb_doubly_linked_list_pool_core.sv
`timescale 1ns / 1ps

module tb_doubly_linked_list_pool_core;
   import dllp_pkg::*;

   localparam int SLOTS = 64;
   localparam logic [6:0] NULL_SLOT = 7'd64;
   localparam int RANDOM_ITEMS = 1450;
   localparam int STALL_LIMIT = 20000;

   // One result of the pool, as seen on the response channel.
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] item_out;
      logic [5:0]  slot;
      logic [6:0]  count;
      logic [31:0] version;
   } pool_rsp_type;

   // The scoreboard keeps its own copy of the pool and works out the result of
   // every accepted item; results are then compared in order of arrival.
   class pool_scoreboard;
      logic [31:0]  items [SLOTS];
      logic [6:0]   next_of [SLOTS];
      logic [6:0]   prev_of [SLOTS];
      logic [6:0]   free_next [SLOTS];
      logic [6:0]   head, tail, free_head, used;
      logic [31:0]  revision;
      pool_rsp_type pending [$];
      int           mismatches;
      int           checked;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            items[i] = '0;
            next_of[i] = '0;
            prev_of[i] = '0;
            free_next[i] = 7'(i + 1);
         end
         head = NULL_SLOT;
         tail = NULL_SLOT;
         free_head = '0;
         used = '0;
         revision = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void free_slot(logic [6:0] s);
         items[s] = '0;
         free_next[s] = free_head;
         free_head = s;
         if (used > 0) used--;
         revision++;
      endfunction

      // Works out the result of one accepted item and updates the copy.
      function void note_request(logic [2:0] kind, logic [31:0] value);
         pool_rsp_type r;
         logic [6:0] s, p, pr, nx;
         int steps;
         r = '0;
         r.status = STATUS_OK;
         if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
            if (value == 0) r.status = STATUS_ZERO;
            else if (used >= SLOTS || free_head >= NULL_SLOT) r.status = STATUS_FULL;
            else begin
               s = free_head;
               free_head = free_next[s];
               items[s] = value;
               used++;
               revision++;
               if (kind == KIND_PUSH_FRONT) begin
                  prev_of[s] = NULL_SLOT;
                  next_of[s] = head;
                  if (head >= NULL_SLOT) tail = s;
                  else prev_of[head] = s;
                  head = s;
               end else begin
                  prev_of[s] = tail;
                  next_of[s] = NULL_SLOT;
                  if (tail >= NULL_SLOT) head = s;
                  else next_of[tail] = s;
                  tail = s;
               end
               r.slot = s[5:0];
            end
         end else if (kind == KIND_POP_FRONT) begin
            if (head >= NULL_SLOT) r.status = STATUS_EMPTY;
            else begin
               s = head;
               r.item_out = items[s];
               head = next_of[s];
               free_slot(s);
               if (head >= NULL_SLOT) tail = NULL_SLOT;
               else prev_of[head] = NULL_SLOT;
               r.slot = s[5:0];
            end
         end else if (kind == KIND_POP_BACK) begin
            if (tail >= NULL_SLOT) r.status = STATUS_EMPTY;
            else begin
               s = tail;
               r.item_out = items[s];
               tail = prev_of[s];
               free_slot(s);
               if (tail >= NULL_SLOT) head = NULL_SLOT;
               else next_of[tail] = NULL_SLOT;
               r.slot = s[5:0];
            end
         end else if (kind == KIND_REMOVE) begin
            if (value == 0) r.status = STATUS_ZERO;
            else begin
               // Walk from the head to the first slot holding the item.
               p = head;
               steps = 0;
               s = NULL_SLOT;
               while (p < NULL_SLOT && steps < SLOTS) begin
                  if (items[p] == value) begin
                     s = p;
                     break;
                  end
                  p = next_of[p];
                  steps++;
               end
               if (s >= NULL_SLOT) r.status = STATUS_NOT_FOUND;
               else begin
                  pr = prev_of[s];
                  nx = next_of[s];
                  if (pr < NULL_SLOT) next_of[pr] = nx;
                  else head = nx;
                  if (nx < NULL_SLOT) prev_of[nx] = pr;
                  else tail = pr;
                  free_slot(s);
                  r.slot = s[5:0];
               end
            end
         end else begin
            r.status = STATUS_NOT_FOUND;
         end
         r.count = used;
         r.version = revision;
         pending.push_back(r);
      endfunction

      function void check_result(pool_rsp_type got);
         pool_rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result with nothing outstanding: %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Result %0d differs: expected %p, got %p", checked, want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = '0;
   logic [31:0] req_item_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_item_out;
   logic [5:0]  rsp_slot;
   logic [6:0]  rsp_count;
   logic [31:0] rsp_version;

   pool_scoreboard pool_sb = new();
   logic [31:0] held_values [$];
   bit          long_stall_req = 1'b0;
   bit          long_stall_done = 1'b0;
   int          idle_cycles = 0;
   int          items_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   doubly_linked_list_pool_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_item_out   (rsp_item_out),
      .rsp_slot       (rsp_slot),
      .rsp_count      (rsp_count),
      .rsp_version    (rsp_version)
   );

   // Both handshakes are sampled at the rising edge, before the nonblocking
   // updates of the driving processes take effect.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) pool_sb.note_request(req_kind, req_item_value);
         if (rsp_valid && rsp_ready)
            pool_sb.check_result({rsp_status, rsp_item_out, rsp_slot, rsp_count, rsp_version});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: a long run of cycles with no item moving on either side.
   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d idle cycles", idle_cycles);
         $display("doubly_linked_list_pool_core: mismatch");
         $finish;
      end
   end

   // Receiver: a random wait before each item, with one long hold-off on request so
   // that the block fills up and stalls its input.
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_stall_req && !long_stall_done) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_stall_done = 1'b1;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offers one item and waits for it to be accepted; gaps adds a random gap first.
   task automatic send_item(input logic [2:0] kind, input logic [31:0] value, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_item_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      // Track what the list may hold so removes mostly hit.
      if ((kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) && value != 0)
         held_values.push_back(value);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pool_sb.pending.size() != 0) @(posedge clock);
   endtask

   // Picks an item value: often from a small set so removes find duplicates,
   // sometimes fully random to toggle every bit.
   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return 32'($urandom_range(1, 40));
      if (sel < 8 && held_values.size() > 0)
         return held_values[$urandom_range(0, held_values.size() - 1)];
      if (sel == 8) return 32'hFFFF_FFFF;
      return $urandom() | 32'd1;
   endfunction

   initial begin
      logic [2:0] kind;
      int mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty pops and removes, zero items, the widest item,
      // every kind including the unused codes, and removes at head, middle
      // and tail.
      send_item(KIND_POP_FRONT, 32'd0, 1'b0);
      send_item(KIND_POP_BACK, 32'd0, 1'b0);
      send_item(KIND_REMOVE, 32'd5, 1'b0);
      send_item(KIND_PUSH_FRONT, 32'd0, 1'b0);
      send_item(KIND_REMOVE, 32'd0, 1'b0);
      send_item(KIND_PUSH_BACK, 32'hFFFF_FFFF, 1'b0);
      send_item(KIND_PUSH_FRONT, 32'h0000_0001, 1'b0);
      send_item(KIND_PUSH_BACK, 32'hA5A5_5A5A, 1'b0);
      send_item(KIND_PUSH_BACK, 32'h5A5A_A5A5, 1'b0);
      send_item(KIND_REMOVE, 32'hA5A5_5A5A, 1'b0);
      send_item(KIND_REMOVE, 32'h0000_0001, 1'b0);
      send_item(KIND_REMOVE, 32'h5A5A_A5A5, 1'b0);
      send_item(KIND_REMOVE, 32'h1234_5678, 1'b0);
      send_item(3'd5, 32'd7, 1'b0);
      send_item(3'd6, 32'd7, 1'b0);
      send_item(3'd7, 32'hFFFF_FFFF, 1'b0);
      send_item(KIND_POP_FRONT, 32'd0, 1'b0);
      send_item(KIND_POP_BACK, 32'd0, 1'b0);
      held_values.delete();

      // Fill the pool completely, push once more into a full pool, then let
      // the sender pause until every result is back.
      for (int i = 0; i < SLOTS; i++) send_item(KIND_PUSH_BACK, 32'(i + 100), i % 3 == 0);
      send_item(KIND_PUSH_FRONT, 32'd999, 1'b0);
      send_item(KIND_REMOVE, 32'(SLOTS + 99), 1'b0);
      wait_drained();

      // The receiver now holds off for a long stretch while items keep coming.
      long_stall_req = 1'b1;
      for (int i = 0; i < 20; i++) send_item(KIND_POP_FRONT, 32'd0, 1'b0);

      // Random part: phases lean towards filling or draining so the pool
      // swings between empty and full; runs without gaps are mixed in.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 200 == 0) mode = $urandom_range(0, 2);
         case ($urandom_range(0, 9))
            0, 1, 2: kind = mode == 0 ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
            3: kind = KIND_PUSH_BACK;
            4: kind = mode == 1 ? KIND_PUSH_FRONT : KIND_POP_FRONT;
            5: kind = KIND_POP_BACK;
            6, 7: kind = KIND_REMOVE;
            8: kind = mode == 2 ? KIND_POP_FRONT : KIND_PUSH_FRONT;
            default: kind = 3'($urandom_range(0, 7));
         endcase
         send_item(kind, ($urandom_range(0, 40) == 0) ? 32'd0 : pick_value(),
                   (n / 100) % 4 != 1);
      end

      wait_drained();
      repeat (200) @(posedge clock);
      $display("Sent %0d items, checked %0d results of every kind,", items_sent,
               pool_sb.checked);
      $display("from an empty pool to a full one, with long receiver stalls.");
      if (pool_sb.mismatches == 0 && pool_sb.pending.size() == 0) begin
         $display("doubly_linked_list_pool_core: match");
      end else begin
         $display("%0d mismatches, %0d results missing", pool_sb.mismatches,
                  pool_sb.pending.size());
         $display("doubly_linked_list_pool_core: mismatch");
      end
      $finish;
   end

endmodule
